### design/nmea_line_checksum_checker_top_macros.svh
// ----------------------------------------------------------------------------
// nmea line checksum checker assertion macros
// clocked, reset-qualified property wrappers for the checker module
// ----------------------------------------------------------------------------
`ifndef NMEA_LINE_CHECKSUM_CHECKER_TOP_MACROS_SVH
`define NMEA_LINE_CHECKSUM_CHECKER_TOP_MACROS_SVH

// property that holds in the same cycle as its antecedent
`define NLCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nlcc assertion failed");

// property that holds in the cycle after its antecedent
`define NLCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nlcc assertion failed");

`endif

### design/nlcc_pkg.sv
// ----------------------------------------------------------------------------
// nlcc_pkg
// shared constants, status codes and helpers of the nmea line checksum checker
// ----------------------------------------------------------------------------
package nlcc_pkg;

    // default saturation limit of the line length counter
    localparam int unsigned LENGTH_LIMIT_DEF = 255;

    // reset value of the minimum line length register
    localparam logic [7:0] MIN_LEN_RESET = 8'd10;

    // character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // verdict codes
    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TRUNCATED = 2'd3
    } line_status_t;

    // uppercase ascii hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] res;
        if (nibble < 4'd10)
        begin
            res = 8'h30 + {4'd0, nibble};
        end
        else
        begin
            res = 8'h37 + {4'd0, nibble};
        end
        return res;
    endfunction

endpackage

### design/nmea_line_checksum_checker_top.sv
// ----------------------------------------------------------------------------
// nmea_line_checksum_checker_top
// xor checksum check of nmea lines, one verdict per line feed
// ----------------------------------------------------------------------------
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+--------------------------------
// in      | input     | in_valid/in_ready  | rx_byte
// out     | output    | out_valid/out_ready| line_status, computed_checksum
// cfg     | input     | cfg_we (no wait)   | cfg_wdata (min_line_length)
//
// one byte per cycle sustained unless a line feed waits behind a held result;
// a byte's line update and verdict are formed while it sits in the input register.
// a line feed's result is registered when it leaves the input register.
// a held result stalls only a line feed in the input register; other bytes
// keep flowing. no clearing pass after reset: all line state resets at once.
//
module nmea_line_checksum_checker_top #(
    parameter int unsigned LENGTH_LIMIT = nlcc_pkg::LENGTH_LIMIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] line_status,
    output logic [7:0] computed_checksum,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);
    import nlcc_pkg::*;

    localparam int unsigned LEN_W = $clog2(LENGTH_LIMIT + 1);
    localparam int unsigned CMP_W = (LEN_W > 8) ? LEN_W : 8;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LENGTH_LIMIT);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;

    // line state
    logic [7:0]       xor_reg, xor_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             dollar_reg, dollar_next;
    logic             star_reg, star_next;
    logic [1:0]       bas_reg, bas_next;
    logic [7:0]       hi_reg, hi_next;
    logic [7:0]       lo_reg, lo_next;

    // configuration and result registers
    logic [7:0]   min_len_val_reg;
    logic         out_valid_reg;
    line_status_t status_reg, status_next;
    logic [7:0]   sum_reg;

    logic s1_is_lf;
    logic s1_go;

    // handshake
    assign s1_is_lf = (s1_byte_reg == CH_LF);
    assign s1_go    = s1_valid_reg && (!s1_is_lf || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_val_reg <= MIN_LEN_RESET;
        end
        else if (cfg_we)
        begin
            min_len_val_reg <= cfg_wdata;
        end
    end

    // line update for the byte in the input register
    always_comb
    begin
        logic first;
        logic [CMP_W-1:0] len_cmp;
        logic [CMP_W-1:0] min_cmp;
        first       = (len_reg == '0);
        len_next    = (len_reg < LEN_MAX) ? len_reg + 1'b1 : len_reg;
        dollar_next = dollar_reg || (s1_byte_reg == CH_DOLLAR);
        star_next   = star_reg;
        bas_next    = bas_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        xor_next    = xor_reg;
        if (star_reg)
        begin
            if (bas_reg == 2'd0)
            begin
                hi_next = s1_byte_reg;
            end
            else if (bas_reg == 2'd1)
            begin
                lo_next = s1_byte_reg;
            end
            if (bas_reg < 2'd2)
            begin
                bas_next = bas_reg + 2'd1;
            end
        end
        else if (s1_byte_reg == CH_STAR)
        begin
            star_next = 1'b1;
        end
        else if (!first && !s1_is_lf)
        begin
            xor_next = xor_reg ^ s1_byte_reg;
        end

        // verdict, malformed first, then truncated
        len_cmp = CMP_W'(len_next);
        min_cmp = CMP_W'(min_len_val_reg);
        priority if (!dollar_next || !star_next || (len_cmp < min_cmp))
        begin
            status_next = ST_MALFORMED;
        end
        else if (bas_next < 2'd2)
        begin
            status_next = ST_TRUNCATED;
        end
        else if ((hi_next == hex_char(xor_next[7:4])) && (lo_next == hex_char(xor_next[3:0])))
        begin
            status_next = ST_VALID;
        end
        else
        begin
            status_next = ST_MISMATCH;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    // line state, cleared after each line feed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg    <= '0;
            len_reg    <= '0;
            dollar_reg <= 1'b0;
            star_reg   <= 1'b0;
            bas_reg    <= '0;
            hi_reg     <= '0;
            lo_reg     <= '0;
        end
        else if (s1_go)
        begin
            if (s1_is_lf)
            begin
                xor_reg    <= '0;
                len_reg    <= '0;
                dollar_reg <= 1'b0;
                star_reg   <= 1'b0;
                bas_reg    <= '0;
                hi_reg     <= '0;
                lo_reg     <= '0;
            end
            else
            begin
                xor_reg    <= xor_next;
                len_reg    <= len_next;
                dollar_reg <= dollar_next;
                star_reg   <= star_next;
                bas_reg    <= bas_next;
                hi_reg     <= hi_next;
                lo_reg     <= lo_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_is_lf)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_is_lf)
        begin
            status_reg <= status_next;
            sum_reg    <= xor_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign line_status       = status_reg;
    assign computed_checksum = sum_reg;

endmodule

### design/nlcc_checker.sv
// ----------------------------------------------------------------------------
// nlcc_checker
// port-level checks of the nmea line checksum checker, bound to the top level
// ----------------------------------------------------------------------------
`include "nmea_line_checksum_checker_top_macros.svh"

module nlcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] line_status,
    input logic [7:0] computed_checksum
);
    import nlcc_pkg::*;

    // a held result keeps its payload
    `NLCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(line_status) && $stable(computed_checksum))

    // with no result pending the input side never stalls
    `NLCC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

    // a line feed behind a stalled result blocks the input until the result leaves
    `NLCC_ASSERT_NEXT(a_lf_blocks, (in_valid && in_ready && (rx_byte == CH_LF)) ##1
        (out_valid && !out_ready), !in_ready || out_ready)

endmodule

bind nmea_line_checksum_checker_top nlcc_checker u_nlcc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .line_status       (line_status),
    .computed_checksum (computed_checksum)
);
